FILE: design/lsrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsrc_pkg;

   localparam int COORD_W = 32;
   // Quotient bits kept below the point where any move saturates the coordinate
   localparam int DIV_STEPS = 33;
   localparam int QUEUE_DEPTH = 4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [COORD_W-1:0] mag_type;

   typedef enum logic [2:0] {
      CSR_WINDOW_LEFT   = 3'd0,
      CSR_WINDOW_BOTTOM = 3'd1,
      CSR_WINDOW_RIGHT  = 3'd2,
      CSR_WINDOW_TOP    = 3'd3,
      CSR_EDGE_MARGIN   = 3'd4
   } csr_index_type;

   // Segment plus widened window, as handed from the front to the back
   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type finish_x;
      coord_type finish_y;
      coord_type lo_x;
      coord_type hi_x;
      coord_type lo_y;
      coord_type hi_y;
   } item_type;

   // Working segment: p is the axis being clipped, s the dependent axis
   typedef struct packed {
      logic      ok;
      logic      swap;
      logic      slope;
      coord_type pa;
      coord_type sa;
      coord_type pb;
      coord_type sb;
      coord_type lo_c;
      coord_type hi_c;
      coord_type lo_n;
      coord_type hi_n;
      coord_type start_x;
      coord_type start_y;
      coord_type finish_x;
      coord_type finish_y;
   } seg_type;

   typedef struct packed {
      logic      en;
      coord_type origin;
      coord_type target;
      mag_type   num;
      mag_type   den;
   } move_req_type;

endpackage

`default_nettype wire

FILE: design/line_segment_rect_clipper_top.sv
// Channel  Dir  Handshake               Payload
// req      in   req_tvalid/req_tready   tdata: start_x, start_y, finish_x, finish_y
// rsp      out  rsp_tvalid/rsp_tready   tdata: clipped coordinates; tuser: visible
// csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// One segment per cycle unless rsp stalls, through four 37-stage move units in
// series (two per axis), each a 32x32 product and a 33-step restoring divider.
// Reset is synchronous and clears valid state and the window registers to zero.
// A stalled rsp freezes the back pipeline; the front stage and a 4-entry queue
// keep taking segments until full. csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module line_segment_rect_clipper_top #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // start_x, start_y, finish_x, finish_y
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // clipped_start_x, clipped_start_y,
                                          // clipped_finish_x, clipped_finish_y
   output logic [0:0]        rsp_tuser,   // visible
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   logic               push, full, q_valid, q_pop;
   lsrc_pkg::item_type push_item, q_item;

   lsrc_front #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_item  (push_item),
      .full       (full)
   );

   lsrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_item)
   );

   lsrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: design/lsrc_move.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrc_move (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic                    in_valid,
   input  wire lsrc_pkg::seg_type       in_seg,
   input  wire lsrc_pkg::move_req_type  in_req,
   output logic                         out_valid,
   output lsrc_pkg::seg_type            out_seg,
   output lsrc_pkg::coord_type          out_value
);

   localparam int CW = lsrc_pkg::COORD_W;
   localparam int NS = lsrc_pkg::DIV_STEPS;
   localparam int STEP_W = NS + 1;
   localparam int SUM_W = STEP_W + 1;

   // stage 0: distance and direction
   logic [CW:0]         diff_in;
   logic [CW:0]         neg_in;
   logic                dir_in;
   logic                en_in;
   lsrc_pkg::mag_type   mag_in;

   logic                v0_ff, en0_ff, dir0_ff;
   lsrc_pkg::seg_type   seg0_ff;
   lsrc_pkg::coord_type origin0_ff;
   lsrc_pkg::mag_type   mag0_ff, num0_ff, den0_ff;

   // stage 1: product
   logic [2*CW-1:0]     prod_in;
   logic                v1_ff, en1_ff, dir1_ff;
   lsrc_pkg::seg_type   seg1_ff;
   lsrc_pkg::coord_type origin1_ff;
   lsrc_pkg::mag_type   den1_ff;
   logic [2*CW-1:0]     prod1_ff;

   // divider stages
   logic                d_v_ff      [NS+1];
   logic                d_en_ff     [NS+1];
   logic                d_dir_ff    [NS+1];
   logic                d_sat_ff    [NS+1];
   lsrc_pkg::seg_type   d_seg_ff    [NS+1];
   lsrc_pkg::coord_type d_origin_ff [NS+1];
   lsrc_pkg::mag_type   d_den_ff    [NS+1];
   lsrc_pkg::mag_type   d_rem_ff    [NS+1];
   logic [NS-1:0]       d_lq_ff     [NS+1];

   // final add
   logic [STEP_W-1:0]   step_in;
   logic [SUM_W-1:0]    sum_in;
   lsrc_pkg::coord_type value_in;
   logic                fv_ff;
   lsrc_pkg::seg_type   fseg_ff;
   lsrc_pkg::coord_type fvalue_ff;

   assign diff_in = {in_req.target[CW-1], in_req.target} - {in_req.origin[CW-1], in_req.origin};
   assign neg_in  = '0 - diff_in;
   assign dir_in  = ~diff_in[CW];
   assign mag_in  = dir_in ? diff_in[CW-1:0] : neg_in[CW-1:0];
   assign en_in   = in_req.en && (in_req.den != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         fv_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         fv_ff <= d_v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg0_ff    <= in_seg;
         en0_ff     <= en_in;
         dir0_ff    <= dir_in;
         origin0_ff <= in_req.origin;
         mag0_ff    <= mag_in;
         num0_ff    <= in_req.num;
         den0_ff    <= in_req.den;
      end
   end

   assign prod_in = mag0_ff * num0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         seg1_ff    <= seg0_ff;
         en1_ff     <= en0_ff;
         dir1_ff    <= dir0_ff;
         origin1_ff <= origin0_ff;
         den1_ff    <= den0_ff;
         prod1_ff   <= prod_in;
      end
   end

   for (genvar k = 0; k <= NS; k++) begin : g_div
      if (k == 0) begin : g_load
         always_ff @(posedge clock) begin
            if (reset) begin
               d_v_ff[k] <= 1'b0;
            end else if (adv) begin
               d_v_ff[k] <= v1_ff;
            end
         end
         // high part already at or above the divisor: move saturates
         always_ff @(posedge clock) begin
            if (adv) begin
               d_en_ff[k]     <= en1_ff;
               d_dir_ff[k]    <= dir1_ff;
               d_seg_ff[k]    <= seg1_ff;
               d_origin_ff[k] <= origin1_ff;
               d_den_ff[k]    <= den1_ff;
               d_sat_ff[k]    <= lsrc_pkg::mag_type'(prod1_ff[2*CW-1:NS]) >= den1_ff;
               d_rem_ff[k]    <= lsrc_pkg::mag_type'(prod1_ff[2*CW-1:NS]);
               d_lq_ff[k]     <= prod1_ff[NS-1:0];
            end
         end
      end else begin : g_step
         logic [CW:0] trial;
         logic [CW:0] trial_sub;
         logic        ge;
         assign trial     = {d_rem_ff[k-1], d_lq_ff[k-1][NS-1]};
         assign trial_sub = trial - {1'b0, d_den_ff[k-1]};
         assign ge        = trial >= {1'b0, d_den_ff[k-1]};
         always_ff @(posedge clock) begin
            if (reset) begin
               d_v_ff[k] <= 1'b0;
            end else if (adv) begin
               d_v_ff[k] <= d_v_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               d_en_ff[k]     <= d_en_ff[k-1];
               d_dir_ff[k]    <= d_dir_ff[k-1];
               d_seg_ff[k]    <= d_seg_ff[k-1];
               d_origin_ff[k] <= d_origin_ff[k-1];
               d_den_ff[k]    <= d_den_ff[k-1];
               d_sat_ff[k]    <= d_sat_ff[k-1];
               d_rem_ff[k]    <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
               d_lq_ff[k]     <= {d_lq_ff[k-1][NS-2:0], ge};
            end
         end
      end
   end

   always_comb begin
      step_in = d_sat_ff[NS] ? {1'b1, {NS{1'b0}}} : {1'b0, d_lq_ff[NS]};
      if (d_dir_ff[NS]) begin
         sum_in = {{(SUM_W-CW){d_origin_ff[NS][CW-1]}}, d_origin_ff[NS]} + {1'b0, step_in};
      end else begin
         sum_in = {{(SUM_W-CW){d_origin_ff[NS][CW-1]}}, d_origin_ff[NS]} - {1'b0, step_in};
      end
      if (!d_en_ff[NS]) begin
         value_in = d_origin_ff[NS];
      end else if ((&sum_in[SUM_W-1:CW-1]) || !(|sum_in[SUM_W-1:CW-1])) begin
         value_in = sum_in[CW-1:0];
      end else if (sum_in[SUM_W-1]) begin
         value_in = {1'b1, {(CW-1){1'b0}}};
      end else begin
         value_in = {1'b0, {(CW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fseg_ff   <= d_seg_ff[NS];
         fvalue_ff <= value_in;
      end
   end

   assign out_valid = fv_ff;
   assign out_seg   = fseg_ff;
   assign out_value = fvalue_ff;

   a_idle_move_keeps_origin : assert property (@(posedge clock) disable iff (reset)
      adv && d_v_ff[NS] && !d_en_ff[NS] |=> out_valid && out_value == $past(d_origin_ff[NS]))
      else $error("disabled move altered the coordinate");

endmodule

`default_nettype wire

FILE: design/lsrc_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrc_axis (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire lsrc_pkg::seg_type in_seg,
   output logic                   out_valid,
   output lsrc_pkg::seg_type      out_seg
);

   lsrc_pkg::seg_type      ent_seg, m1_seg, mid_seg, m2_seg, ext_seg_in, out_seg_ff;
   lsrc_pkg::move_req_type m1_req, m2_req;
   lsrc_pkg::coord_type    m1_value, m2_value;
   logic                   m1_valid, m2_valid, out_valid_ff;
   logic                   swp, rej, mv1, mv2;

   // order endpoints so that a is the low end on this axis; clip a to the low edge
   always_comb begin
      ent_seg = in_seg;
      swp = $signed(in_seg.pa) > $signed(in_seg.pb);
      if (swp) begin
         ent_seg.pa = in_seg.pb;
         ent_seg.sa = in_seg.sb;
         ent_seg.pb = in_seg.pa;
         ent_seg.sb = in_seg.sa;
      end
      ent_seg.swap  = swp;
      rej = ($signed(ent_seg.pb) < $signed(in_seg.lo_c))
            || ($signed(ent_seg.pa) > $signed(in_seg.hi_c));
      ent_seg.ok    = in_seg.ok && !rej;
      ent_seg.slope = in_seg.pa != in_seg.pb;
      mv1 = ent_seg.ok && ent_seg.slope && ($signed(ent_seg.pa) <= $signed(in_seg.lo_c));
      m1_req.en     = mv1;
      m1_req.origin = ent_seg.sa;
      m1_req.target = ent_seg.sb;
      m1_req.num    = in_seg.lo_c - ent_seg.pa;
      m1_req.den    = ent_seg.pb - ent_seg.pa;
      if (mv1) begin
         ent_seg.pa = in_seg.lo_c;
      end
   end

   lsrc_move u_move_lo (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid),
      .in_seg    (ent_seg),
      .in_req    (m1_req),
      .out_valid (m1_valid),
      .out_seg   (m1_seg),
      .out_value (m1_value)
   );

   // clip b to the high edge, measured from the already clipped a
   always_comb begin
      mid_seg    = m1_seg;
      mid_seg.sa = m1_value;
      mv2 = m1_seg.ok && m1_seg.slope && ($signed(m1_seg.pb) >= $signed(m1_seg.hi_c));
      m2_req.en     = mv2;
      m2_req.origin = m1_seg.sb;
      m2_req.target = m1_value;
      m2_req.num    = m1_seg.pb - m1_seg.hi_c;
      m2_req.den    = m1_seg.pb - m1_seg.pa;
      if (mv2) begin
         mid_seg.pb = m1_seg.hi_c;
      end
   end

   lsrc_move u_move_hi (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m1_valid),
      .in_seg    (mid_seg),
      .in_req    (m2_req),
      .out_valid (m2_valid),
      .out_seg   (m2_seg),
      .out_value (m2_value)
   );

   // restore the original endpoint order
   always_comb begin
      ext_seg_in    = m2_seg;
      ext_seg_in.sb = m2_value;
      if (m2_seg.swap) begin
         ext_seg_in.pa = m2_seg.pb;
         ext_seg_in.sa = m2_value;
         ext_seg_in.pb = m2_seg.pa;
         ext_seg_in.sb = m2_seg.sa;
      end
      ext_seg_in.swap = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= m2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_seg_ff <= ext_seg_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_seg   = out_seg_ff;

endmodule

`default_nettype wire

FILE: design/lsrc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire lsrc_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output lsrc_pkg::item_type      head_item
);

   localparam int DEPTH = lsrc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   lsrc_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff, count_in;

   assign count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full       = count_ff == (PTR_W+1)'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = mem_ff[rd_ptr_ff];

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: design/lsrc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrc_front #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_data,
   output logic               push,
   output lsrc_pkg::item_type push_item,
   input  wire logic          full
);

   localparam int CW = lsrc_pkg::COORD_W;
   localparam int MARGIN_W = 16 + COORD_FRAC_BITS;
   localparam int SUM_W = ((MARGIN_W > CW) ? MARGIN_W : CW) + 2;

   lsrc_pkg::coord_type left_ff, bottom_ff, right_ff, top_ff;
   logic [15:0]         margin_ff;
   logic [MARGIN_W-1:0] margin_sh;
   logic                f_valid_ff, f_valid_in, req_xfer;
   lsrc_pkg::item_type  f_item_ff, f_item_in;

   function automatic lsrc_pkg::coord_type widen(input lsrc_pkg::coord_type e,
                                                 input logic [MARGIN_W-1:0] m,
                                                 input logic up);
      logic [SUM_W-1:0] ev;
      logic [SUM_W-1:0] mv;
      logic [SUM_W-1:0] s;
      ev = {{(SUM_W-CW){e[CW-1]}}, e};
      mv = {{(SUM_W-MARGIN_W){1'b0}}, m};
      s  = up ? ev + mv : ev - mv;
      if ((&s[SUM_W-1:CW-1]) || !(|s[SUM_W-1:CW-1])) begin
         return s[CW-1:0];
      end else if (s[SUM_W-1]) begin
         return {1'b1, {(CW-1){1'b0}}};
      end else begin
         return {1'b0, {(CW-1){1'b1}}};
      end
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         bottom_ff <= '0;
         right_ff  <= '0;
         top_ff    <= '0;
         margin_ff <= '0;
      end else if (csr_valid) begin
         unique case (lsrc_pkg::csr_index_type'(csr_index))
            lsrc_pkg::CSR_WINDOW_LEFT:   left_ff   <= csr_data;
            lsrc_pkg::CSR_WINDOW_BOTTOM: bottom_ff <= csr_data;
            lsrc_pkg::CSR_WINDOW_RIGHT:  right_ff  <= csr_data;
            lsrc_pkg::CSR_WINDOW_TOP:    top_ff    <= csr_data;
            lsrc_pkg::CSR_EDGE_MARGIN:   margin_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign margin_sh = MARGIN_W'(margin_ff) << COORD_FRAC_BITS;

   always_comb begin
      f_item_in.start_x  = req_tdata[31:0];
      f_item_in.start_y  = req_tdata[63:32];
      f_item_in.finish_x = req_tdata[95:64];
      f_item_in.finish_y = req_tdata[127:96];
      f_item_in.lo_x     = widen(left_ff, margin_sh, 1'b0);
      f_item_in.hi_x     = widen(right_ff, margin_sh, 1'b1);
      f_item_in.lo_y     = widen(bottom_ff, margin_sh, 1'b0);
      f_item_in.hi_y     = widen(top_ff, margin_sh, 1'b1);
   end

   assign push       = f_valid_ff && !full;
   assign req_tready = !f_valid_ff || !full;
   assign req_xfer   = req_tvalid && req_tready;
   assign f_valid_in = req_xfer || (f_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         f_item_ff <= f_item_in;
      end
   end

   assign push_item = f_item_ff;

endmodule

`default_nettype wire

FILE: design/lsrc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire lsrc_pkg::item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [127:0]            rsp_tdata,
   output logic [0:0]              rsp_tuser
);

   logic              adv;
   logic              x_valid, y_valid;
   lsrc_pkg::seg_type x_in, x_seg, y_in, y_seg;
   logic              rsp_valid_ff;
   logic [127:0]      rsp_data_ff, rsp_data_in;
   logic              rsp_vis_ff;

   // hold the whole pipeline while a result waits at the output
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = adv && q_valid;

   always_comb begin
      x_in.ok       = 1'b1;
      x_in.swap     = 1'b0;
      x_in.slope    = 1'b0;
      x_in.pa       = q_item.start_x;
      x_in.sa       = q_item.start_y;
      x_in.pb       = q_item.finish_x;
      x_in.sb       = q_item.finish_y;
      x_in.lo_c     = q_item.lo_x;
      x_in.hi_c     = q_item.hi_x;
      x_in.lo_n     = q_item.lo_y;
      x_in.hi_n     = q_item.hi_y;
      x_in.start_x  = q_item.start_x;
      x_in.start_y  = q_item.start_y;
      x_in.finish_x = q_item.finish_x;
      x_in.finish_y = q_item.finish_y;
   end

   lsrc_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (q_pop),
      .in_seg    (x_in),
      .out_valid (x_valid),
      .out_seg   (x_seg)
   );

   // exchange axes for the y pass
   always_comb begin
      y_in      = x_seg;
      y_in.pa   = x_seg.sa;
      y_in.sa   = x_seg.pa;
      y_in.pb   = x_seg.sb;
      y_in.sb   = x_seg.pb;
      y_in.lo_c = x_seg.lo_n;
      y_in.hi_c = x_seg.hi_n;
      y_in.lo_n = x_seg.lo_c;
      y_in.hi_n = x_seg.hi_c;
   end

   lsrc_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (x_valid),
      .in_seg    (y_in),
      .out_valid (y_valid),
      .out_seg   (y_seg)
   );

   always_comb begin
      if (y_seg.ok) begin
         rsp_data_in = {y_seg.pb, y_seg.sb, y_seg.pa, y_seg.sa};
      end else begin
         rsp_data_in = {y_seg.finish_y, y_seg.finish_x, y_seg.start_y, y_seg.start_x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= y_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_vis_ff  <= y_seg.ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_vis_ff;

endmodule

`default_nettype wire
